// File: sv/joint_quaternion_midpoint_smoother_top_macros.svh
// Assertion helpers shared by the smoother RTL.
// Both expect a clock named i_clk in the enclosing module.
`ifndef JOINT_QUATERNION_MIDPOINT_SMOOTHER_TOP_MACROS_SVH
`define JOINT_QUATERNION_MIDPOINT_SMOOTHER_TOP_MACROS_SVH

// Check on every clock edge, reset included.
`define JQMS_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

// Check outside reset (synchronous, active low i_rst_n).
`define JQMS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`endif

// File: sv/jqms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package jqms_pkg;

    // Joint slots and sizing
    localparam int NUM_JOINTS = 25;
    localparam int SLOTS      = 32;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int FRAC_BITS  = 14;

    // Quaternion components
    localparam int Q_W    = 16;
    localparam int NCOMP  = 4;
    localparam int COMP_W = $clog2(NCOMP);

    // Sum, magnitude and square widths
    localparam int S_W   = Q_W + 1;
    localparam int MAG_W = S_W;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int N_W   = SQ_W + COMP_W;

    // Square root of n * 2^28
    localparam int SQRT_SHIFT = 28;
    localparam int ROOT_W     = (N_W + SQRT_SHIFT + 1) / 2;
    localparam int V_W        = 2 * ROOT_W;

    // Division (|s| * 2^(FRAC_BITS+14) + m/2) / m, saturated to 15 bits
    localparam int DIV_SHIFT = FRAC_BITS + 14;
    localparam int NUM_W     = MAG_W + DIV_SHIFT;
    localparam int Q_BITS    = Q_W - 1;
    localparam int MAG_MAX   = (2 ** Q_BITS) - 1;
    localparam int HI_W      = NUM_W - Q_BITS;

    // Shared compare/subtract unit and step counter
    localparam int ALU_W = (HI_W > ROOT_W + 2) ? HI_W : ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    typedef logic signed [Q_W-1:0] t_comp;
    // Element 0 is w, then x, y, z
    typedef t_comp [NCOMP-1:0] t_quat;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_quat            raw;
        t_quat            filt;
        logic             untracked;
    } t_store_wr;

    typedef struct packed {
        logic  started;
        logic  untracked;
        t_quat raw;
        t_quat filt;
    } t_store_rd;

endpackage
`default_nettype wire

// File: sv/jqms_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface jqms_in_if;
    import jqms_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        joint_index;
    logic signed [Q_W-1:0]   raw_w;
    logic signed [Q_W-1:0]   raw_x;
    logic signed [Q_W-1:0]   raw_y;
    logic signed [Q_W-1:0]   raw_z;
    logic                    is_tracked;

    modport source (output valid, joint_index, raw_w, raw_x, raw_y, raw_z, is_tracked,
                    input ready);
    modport sink   (input valid, joint_index, raw_w, raw_x, raw_y, raw_z, is_tracked,
                    output ready);
endinterface

interface jqms_out_if;
    import jqms_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_joint;
    logic signed [Q_W-1:0]   filt_w;
    logic signed [Q_W-1:0]   filt_x;
    logic signed [Q_W-1:0]   filt_y;
    logic signed [Q_W-1:0]   filt_z;

    modport source (output valid, out_joint, filt_w, filt_x, filt_y, filt_z, input ready);
    modport sink   (input valid, out_joint, filt_w, filt_x, filt_y, filt_z, output ready);
endinterface
`default_nettype wire

// File: sv/jqms_store.sv
`timescale 1ns / 1ps
`default_nettype none
module jqms_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [jqms_pkg::IDX_W-1:0] i_rd_addr,
    output jqms_pkg::t_store_rd        o_rd,
    input  jqms_pkg::t_store_wr        i_wr
);
    import jqms_pkg::*;

    typedef struct packed {
        t_quat raw;
        t_quat filt;
    } t_entry;

    t_entry           r_mem [SLOTS];
    t_entry           r_rd_entry;
    logic [SLOTS-1:0] r_started;
    logic [SLOTS-1:0] r_untracked;
    logic             r_rd_started;
    logic             r_rd_untracked;

    // Quaternion memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= '{raw: i_wr.raw, filt: i_wr.filt};
        end
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    // Per-joint flags; a joint not yet started has its entry read but not used
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started      <= '0;
            r_untracked    <= '1;
            r_rd_started   <= 1'b0;
            r_rd_untracked <= 1'b1;
        end else begin
            if (i_wr.en) begin
                r_started[i_wr.addr]   <= 1'b1;
                r_untracked[i_wr.addr] <= i_wr.untracked;
            end
            if (i_rd_en) begin
                r_rd_started   <= r_started[i_rd_addr];
                r_rd_untracked <= r_untracked[i_rd_addr];
            end
        end
    end

    assign o_rd = '{started: r_rd_started, untracked: r_rd_untracked,
                    raw: r_rd_entry.raw, filt: r_rd_entry.filt};

endmodule
`default_nettype wire

// File: sv/jqms_csu.sv
`timescale 1ns / 1ps
`default_nettype none
module jqms_csu (
    input  logic [jqms_pkg::ALU_W-1:0] i_a,
    input  logic [jqms_pkg::ALU_W-1:0] i_b,
    output logic                       o_ge,
    output logic [jqms_pkg::ALU_W-1:0] o_diff
);
    import jqms_pkg::*;

    logic [ALU_W:0] diff_ext;

    // Subtract with borrow out; no borrow means a >= b
    assign diff_ext = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge     = ~diff_ext[ALU_W];
    assign o_diff   = diff_ext[ALU_W-1:0];

endmodule
`default_nettype wire

// File: sv/jqms_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "joint_quaternion_midpoint_smoother_top_macros.svh"
module jqms_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    jqms_in_if.sink                    i_in,
    jqms_out_if.source                 o_out,
    output logic                       o_rd_en,
    output logic [jqms_pkg::IDX_W-1:0] o_rd_addr,
    input  jqms_pkg::t_store_rd        i_store_rd,
    output jqms_pkg::t_store_wr        o_store_wr
);
    import jqms_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SQUARE,
        S_CHECK,
        S_SQRT,
        S_DLOAD,
        S_DOVF,
        S_DSTEP,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_joint, n_joint;
    t_quat              r_raw, n_raw;
    logic               r_tracked, n_tracked;
    logic [MAG_W-1:0]   r_mag [NCOMP];
    logic [MAG_W-1:0]   n_mag [NCOMP];
    logic [NCOMP-1:0]   r_neg, n_neg;
    logic [COMP_W-1:0]  r_comp, n_comp;
    logic [N_W-1:0]     r_n, n_n;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [V_W-1:0]     r_v, n_v;
    logic [ROOT_W-1:0]  r_root, n_root;
    logic [ALU_W-1:0]   r_rem, n_rem;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [Q_BITS-1:0]  r_lo, n_lo;
    logic [Q_BITS-1:0]  r_q, n_q;
    t_quat              r_res, n_res;
    logic               r_out_valid, n_out_valid;
    logic [IDX_W-1:0]   r_out_joint, n_out_joint;
    t_quat              r_out_q, n_out_q;

    logic               in_acc;
    logic               in_range;
    logic               out_free;
    t_quat              ref_q;
    logic signed [S_W-1:0] s_c [NCOMP];
    logic [SQ_W-1:0]    sq;
    logic [ALU_W-1:0]   alu_a;
    logic [ALU_W-1:0]   alu_b;
    logic [ALU_W-1:0]   alu_diff;
    logic               alu_ge;

    function automatic t_comp apply_sign(input logic neg, input logic [Q_BITS-1:0] q);
        logic [Q_W-1:0] mag;
        mag = {1'b0, q};
        return neg ? t_comp'(-mag) : t_comp'(mag);
    endfunction

    // Handshake and store read at acceptance
    assign in_acc      = i_in.valid && i_in.ready;
    assign in_range    = {1'b0, i_in.joint_index} < (IDX_W + 1)'(NUM_JOINTS);
    assign i_in.ready  = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_out.ready;
    assign o_rd_en     = in_acc;
    assign o_rd_addr   = i_in.joint_index;

    // Reference is the last filtered value after an untracked item
    assign ref_q = i_store_rd.untracked ? i_store_rd.filt : i_store_rd.raw;

    always_comb begin
        for (int i = 0; i < NCOMP; i++) begin
            s_c[i] = S_W'(r_raw[i]) + S_W'(ref_q[i]);
        end
    end

    // Shared square unit for the length accumulation
    assign sq = r_mag[r_comp] * r_mag[r_comp];

    // Operand select for the shared compare/subtract unit
    always_comb begin
        unique case (r_state)
            S_SQRT: begin
                alu_a = ALU_W'({r_rem[ROOT_W-1:0], r_v[V_W-1 -: 2]});
                alu_b = ALU_W'({r_root, 2'b01});
            end
            S_DOVF: begin
                alu_a = ALU_W'(r_num[NUM_W-1:Q_BITS]);
                alu_b = ALU_W'(r_root);
            end
            default: begin
                alu_a = ALU_W'({r_rem[ROOT_W-1:0], r_lo[Q_BITS-1]});
                alu_b = ALU_W'(r_root);
            end
        endcase
    end

    jqms_csu u_csu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_ge   (alu_ge),
        .o_diff (alu_diff)
    );

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_joint     = r_joint;
        n_raw       = r_raw;
        n_tracked   = r_tracked;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_comp      = r_comp;
        n_n         = r_n;
        n_cnt       = r_cnt;
        n_v         = r_v;
        n_root      = r_root;
        n_rem       = r_rem;
        n_num       = r_num;
        n_lo        = r_lo;
        n_q         = r_q;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_joint = r_out_joint;
        n_out_q     = r_out_q;

        // Drop the output item once taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_joint   = i_in.joint_index;
                    n_raw     = {i_in.raw_z, i_in.raw_y, i_in.raw_x, i_in.raw_w};
                    n_tracked = i_in.is_tracked;
                    if (in_range) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                if (!i_store_rd.started) begin
                    n_res   = r_raw;
                    n_state = S_DONE;
                end else begin
                    for (int i = 0; i < NCOMP; i++) begin
                        n_neg[i] = s_c[i][S_W-1];
                        n_mag[i] = s_c[i][S_W-1] ? MAG_W'(-s_c[i]) : MAG_W'(s_c[i]);
                    end
                    n_comp  = '0;
                    n_n     = '0;
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: begin
                n_n    = r_n + N_W'(sq);
                n_comp = r_comp + 1'b1;
                if (r_comp == COMP_W'(NCOMP - 1)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_n == '0) begin
                    n_res   = r_raw;
                    n_state = S_DONE;
                end else begin
                    n_v     = V_W'({r_n, {SQRT_SHIFT{1'b0}}});
                    n_rem   = '0;
                    n_root  = '0;
                    n_cnt   = CNT_W'(ROOT_W - 1);
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                // One root bit a step, two radicand bits in
                n_v = r_v << 2;
                if (alu_ge) begin
                    n_rem  = alu_diff;
                    n_root = {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = alu_a;
                    n_root = {r_root[ROOT_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_comp  = '0;
                    n_state = S_DLOAD;
                end
            end
            S_DLOAD: begin
                n_num   = NUM_W'({r_mag[r_comp], {DIV_SHIFT{1'b0}}})
                        + NUM_W'(r_root[ROOT_W-1:1]);
                n_state = S_DOVF;
            end
            S_DOVF: begin
                // Quotient would not fit: saturate and skip the steps
                if (alu_ge) begin
                    n_res[r_comp] = apply_sign(r_neg[r_comp], Q_BITS'(MAG_MAX));
                    n_comp        = r_comp + 1'b1;
                    n_state       = (r_comp == COMP_W'(NCOMP - 1)) ? S_DONE : S_DLOAD;
                end else begin
                    n_rem   = alu_a;
                    n_lo    = r_num[Q_BITS-1:0];
                    n_q     = '0;
                    n_cnt   = CNT_W'(Q_BITS - 1);
                    n_state = S_DSTEP;
                end
            end
            S_DSTEP: begin
                // Restoring division, one quotient bit a step
                n_lo  = r_lo << 1;
                n_rem = alu_ge ? alu_diff : alu_a;
                n_q   = {r_q[Q_BITS-2:0], alu_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_res[r_comp] = apply_sign(r_neg[r_comp], n_q);
                    n_comp        = r_comp + 1'b1;
                    n_state       = (r_comp == COMP_W'(NCOMP - 1)) ? S_DONE : S_DLOAD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_joint = r_joint;
                    n_out_q     = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, working registers and output register
    always_ff @(posedge i_clk) begin
        r_joint     <= n_joint;
        r_raw       <= n_raw;
        r_tracked   <= n_tracked;
        r_mag       <= n_mag;
        r_neg       <= n_neg;
        r_comp      <= n_comp;
        r_n         <= n_n;
        r_cnt       <= n_cnt;
        r_v         <= n_v;
        r_root      <= n_root;
        r_rem       <= n_rem;
        r_num       <= n_num;
        r_lo        <= n_lo;
        r_q         <= n_q;
        r_res       <= n_res;
        r_out_joint <= n_out_joint;
        r_out_q     <= n_out_q;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Commit the joint's history as the result enters the output register
    always_comb begin
        o_store_wr.en        = (r_state == S_DONE) && out_free;
        o_store_wr.addr      = r_joint;
        o_store_wr.raw       = r_raw;
        o_store_wr.filt      = r_res;
        o_store_wr.untracked = !r_tracked;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_joint = r_out_joint;
    assign o_out.filt_w    = r_out_q[0];
    assign o_out.filt_x    = r_out_q[1];
    assign o_out.filt_y    = r_out_q[2];
    assign o_out.filt_z    = r_out_q[3];

    `JQMS_ASSERT_CLK(a_rst_idle, !i_rst_n |=> (r_state == S_IDLE && !r_out_valid), "reset left work pending")
    `JQMS_ASSERT_RST(a_drop, (in_acc && !in_range) |=> (r_state == S_IDLE), "out of range item not dropped")
    `JQMS_ASSERT_RST(a_wr_out, o_store_wr.en |=> r_out_valid, "history written without a result")
    `JQMS_ASSERT_RST(a_sqrt_nz, (r_state == S_SQRT) |-> (r_n != '0), "square root of zero length")
    `JQMS_ASSERT_RST(a_div_rem, (r_state == S_DSTEP) |-> (r_rem < ALU_W'(r_root)), "remainder not below divisor")

endmodule
`default_nettype wire

// File: sv/joint_quaternion_midpoint_smoother_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Per-joint orientation smoother. Each input item on i_in carries a joint
// index, a Q1.14 quaternion and a tracked flag; each item with an index
// below 25 gives one output item on o_out with the same joint index and the
// filtered quaternion. Items with a larger index are taken and dropped.
// A joint's first item passes straight through; later items give
// normalize(raw + reference), or raw if that sum is zero, worked out by
// one shared 17x17 squarer and one shared compare/subtract unit under a
// sequencer: the four components are squared in turn, then 32 square-root
// steps, then per component a load, an overflow check and 15 divide steps;
// a component that saturates skips its divide steps. i_in.ready is high
// only between items, so a new item is taken only once the last one has
// left the sequencer for the output register.
// o_out is a register: a finished item waits there while the next item is
// accepted and worked on; if it is still not taken when the next result is
// ready, the block holds that result and stays not ready.
// Synchronous reset on i_rst_n clears the sequencer, the output register
// and per-joint started flags, sets untracked flags at once; no clearing pass.
module joint_quaternion_midpoint_smoother_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jqms_in_if.sink    i_in,
    jqms_out_if.source o_out
);
    import jqms_pkg::*;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    t_store_rd        store_rd;
    t_store_wr        store_wr;

    jqms_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd      (store_rd),
        .i_wr      (store_wr)
    );

    jqms_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_out      (o_out),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_store_rd (store_rd),
        .o_store_wr (store_wr)
    );

endmodule
`default_nettype wire
